FILE: src/bmp24_stream_decoder_top_macros.svh
// Assertion macros for the BMP stream decoder.
`ifndef BMP24_STREAM_DECODER_TOP_MACROS_SVH
`define BMP24_STREAM_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define BSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/bsd_pkg.sv
// Types and constants for the BMP stream decoder.
`default_nettype none

package bsd_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
    localparam logic [15:0] BMP_BITS      = 16'd24;
    localparam logic [7:0]  ALPHA_OPAQUE  = 8'hFF;
    localparam logic [31:0] HEADER_BYTES  = 32'd54;

    // Byte offsets of header fields
    localparam logic [5:0] OFS_SIGNATURE   = 6'd0;
    localparam logic [5:0] OFS_RESERVED    = 6'd6;
    localparam logic [5:0] OFS_PIXEL_START = 6'd10;
    localparam logic [5:0] OFS_WIDTH       = 6'd18;
    localparam logic [5:0] OFS_HEIGHT      = 6'd22;
    localparam logic [5:0] OFS_BITS        = 6'd28;
    localparam logic [5:0] OFS_COMPRESSION = 6'd30;
    localparam logic [5:0] FILE_HEADER_END = 6'd13;
    localparam logic [5:0] INFO_HEADER_END = 6'd53;

    typedef enum logic [2:0] {
        KIND_PIXEL     = 3'd0,
        KIND_HEADER_OK = 3'd1,
        KIND_INVALID   = 3'd2,
        KIND_TRUNCATED = 3'd3,
        KIND_END_OK    = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_REJECTED = 3'd1,
        PH_SKIP     = 3'd2,
        PH_PIXELS   = 3'd3,
        PH_DONE     = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_marker;
    } byte_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] pixel_value;
        logic [11:0] pixel_row;
        logic [11:0] pixel_column;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic        last_pixel;
    } result_item_t;

endpackage

`default_nettype wire

FILE: src/bmp24_stream_decoder_top.sv
// Top level of the 24-bit uncompressed BMP stream decoder.
`default_nettype none

`include "bmp24_stream_decoder_top_macros.svh"

// Takes a BMP file one byte item per cycle and checks its 54-byte header, then
// emits one opaque ABGR pixel item for every BGR triplet, skipping row padding.
// Header accept, invalid format, truncation and clean end are reported as items
// of their own kind. Every input item is parsed in the cycle it is accepted and
// its result, if any, appears in the result register in the following cycle; a new
// byte is taken every cycle unless a result waits behind a stalled output.
// An end marker item carries no byte and rearms the parser for the next file.
module bmp24_stream_decoder_top (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    byte_valid,
    output logic                   byte_stall,
    input  bsd_pkg::byte_item_t    byte_item,
    output logic                   result_valid,
    input  wire                    result_stall,
    output bsd_pkg::result_item_t  result_item
);

    bsd_pkg::phase_t        phase_reg, phase_next;
    logic [31:0]            byte_position_reg, byte_position_next;
    logic [15:0]            signature_reg, signature_next;
    logic [31:0]            reserved_reg, reserved_next;
    logic [31:0]            pixel_offset_reg, pixel_offset_next;
    logic [31:0]            header_width_reg, header_width_next;
    logic [31:0]            header_height_reg, header_height_next;
    logic [15:0]            bits_reg, bits_next;
    logic [31:0]            compression_reg, compression_next;
    logic [12:0]            width_reg, width_next;
    logic [12:0]            height_reg, height_next;
    logic [12:0]            row_count_reg, row_count_next;
    logic [12:0]            column_count_reg, column_count_next;
    logic [1:0]             triplet_phase_reg, triplet_phase_next;
    logic [15:0]            held_blue_green_reg, held_blue_green_next;
    logic [1:0]             padding_left_reg, padding_left_next;
    logic                   result_valid_reg;
    bsd_pkg::result_item_t  result_reg;

    logic                   accept;
    logic                   emit;
    bsd_pkg::result_item_t  res;
    logic [5:0]             pos;
    logic [31:0]            abs_height;
    logic [12:0]            column_inc;
    logic [12:0]            row_inc;
    logic                   file_bad;
    logic                   info_bad;

    assign byte_stall   = result_valid_reg && result_stall;
    assign accept       = byte_valid && !byte_stall;
    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

    assign pos        = byte_position_reg[5:0];
    assign abs_height = header_height_next[31] ? (~header_height_next + 32'd1)
                                               : header_height_next;
    assign column_inc = column_count_reg + 13'd1;
    assign row_inc    = row_count_reg + 13'd1;

    always_comb
    begin
        phase_next           = phase_reg;
        byte_position_next   = byte_position_reg;
        signature_next       = signature_reg;
        reserved_next        = reserved_reg;
        pixel_offset_next    = pixel_offset_reg;
        header_width_next    = header_width_reg;
        header_height_next   = header_height_reg;
        bits_next            = bits_reg;
        compression_next     = compression_reg;
        width_next           = width_reg;
        height_next          = height_reg;
        row_count_next       = row_count_reg;
        column_count_next    = column_count_reg;
        triplet_phase_next   = triplet_phase_reg;
        held_blue_green_next = held_blue_green_reg;
        padding_left_next    = padding_left_reg;
        emit                 = 1'b0;
        res                  = '0;
        file_bad             = 1'b0;
        info_bad             = 1'b0;

        if (byte_item.end_marker)
        begin
            phase_next           = bsd_pkg::PH_HEADER;
            byte_position_next   = '0;
            signature_next       = '0;
            reserved_next        = '0;
            pixel_offset_next    = '0;
            header_width_next    = '0;
            header_height_next   = '0;
            bits_next            = '0;
            compression_next     = '0;
            width_next           = '0;
            height_next          = '0;
            row_count_next       = '0;
            column_count_next    = '0;
            triplet_phase_next   = '0;
            held_blue_green_next = '0;
            padding_left_next    = '0;
            emit                 = (phase_reg != bsd_pkg::PH_REJECTED);
            res.kind             = (phase_reg == bsd_pkg::PH_DONE) ? bsd_pkg::KIND_END_OK
                                                                   : bsd_pkg::KIND_TRUNCATED;
        end
        else
        begin
            case (phase_reg)
                bsd_pkg::PH_HEADER:
                begin
                    byte_position_next = byte_position_reg + 32'd1;
                    if (pos <= bsd_pkg::OFS_SIGNATURE + 6'd1)
                        signature_next[8*(pos[0]) +: 8] = byte_item.data_byte;
                    else if (pos >= bsd_pkg::OFS_RESERVED && pos <= bsd_pkg::OFS_RESERVED + 6'd3)
                        reserved_next[8*(2'(pos - bsd_pkg::OFS_RESERVED)) +: 8] =
                            byte_item.data_byte;
                    else if (pos >= bsd_pkg::OFS_PIXEL_START &&
                             pos <= bsd_pkg::OFS_PIXEL_START + 6'd3)
                        pixel_offset_next[8*(2'(pos - bsd_pkg::OFS_PIXEL_START)) +: 8] =
                            byte_item.data_byte;
                    else if (pos >= bsd_pkg::OFS_WIDTH && pos <= bsd_pkg::OFS_WIDTH + 6'd3)
                        header_width_next[8*(2'(pos - bsd_pkg::OFS_WIDTH)) +: 8] =
                            byte_item.data_byte;
                    else if (pos >= bsd_pkg::OFS_HEIGHT && pos <= bsd_pkg::OFS_HEIGHT + 6'd3)
                        header_height_next[8*(2'(pos - bsd_pkg::OFS_HEIGHT)) +: 8] =
                            byte_item.data_byte;
                    else if (pos >= bsd_pkg::OFS_BITS && pos <= bsd_pkg::OFS_BITS + 6'd1)
                        bits_next[8*(pos[0]) +: 8] = byte_item.data_byte;
                    else if (pos >= bsd_pkg::OFS_COMPRESSION &&
                             pos <= bsd_pkg::OFS_COMPRESSION + 6'd3)
                        compression_next[8*(2'(pos - bsd_pkg::OFS_COMPRESSION)) +: 8] =
                            byte_item.data_byte;

                    file_bad = (signature_next != bsd_pkg::BMP_SIGNATURE) ||
                               (reserved_next != 32'd0) ||
                               (pixel_offset_next < bsd_pkg::HEADER_BYTES);
                    info_bad = (bits_next != bsd_pkg::BMP_BITS) ||
                               (compression_next != 32'd0) ||
                               (header_width_next > 32'(bsd_pkg::MAX_WIDTH)) ||
                               (abs_height > 32'(bsd_pkg::MAX_HEIGHT));

                    if (pos == bsd_pkg::FILE_HEADER_END && file_bad)
                    begin
                        phase_next = bsd_pkg::PH_REJECTED;
                        emit       = 1'b1;
                        res.kind   = bsd_pkg::KIND_INVALID;
                    end
                    else if (pos == bsd_pkg::INFO_HEADER_END)
                    begin
                        emit = 1'b1;
                        if (info_bad)
                        begin
                            phase_next = bsd_pkg::PH_REJECTED;
                            res.kind   = bsd_pkg::KIND_INVALID;
                        end
                        else
                        begin
                            width_next       = header_width_next[12:0];
                            height_next      = abs_height[12:0];
                            res.kind         = bsd_pkg::KIND_HEADER_OK;
                            res.image_width  = header_width_next[12:0];
                            res.image_height = abs_height[12:0];
                            if (header_width_next == 32'd0 || abs_height == 32'd0)
                                phase_next = bsd_pkg::PH_DONE;
                            else if (pixel_offset_next == bsd_pkg::HEADER_BYTES)
                                phase_next = bsd_pkg::PH_PIXELS;
                            else
                                phase_next = bsd_pkg::PH_SKIP;
                        end
                    end
                end
                bsd_pkg::PH_SKIP:
                begin
                    byte_position_next = byte_position_reg + 32'd1;
                    if (byte_position_next == pixel_offset_reg)
                        phase_next = bsd_pkg::PH_PIXELS;
                end
                bsd_pkg::PH_PIXELS:
                begin
                    if (padding_left_reg != 2'd0)
                        padding_left_next = padding_left_reg - 2'd1;
                    else if (triplet_phase_reg == 2'd0)
                    begin
                        held_blue_green_next = {byte_item.data_byte, 8'd0};
                        triplet_phase_next   = 2'd1;
                    end
                    else if (triplet_phase_reg == 2'd1)
                    begin
                        held_blue_green_next = {held_blue_green_reg[15:8], byte_item.data_byte};
                        triplet_phase_next   = 2'd2;
                    end
                    else
                    begin
                        triplet_phase_next = 2'd0;
                        emit               = 1'b1;
                        res.kind           = bsd_pkg::KIND_PIXEL;
                        res.pixel_value    = {bsd_pkg::ALPHA_OPAQUE, held_blue_green_reg,
                                              byte_item.data_byte};
                        res.pixel_row      = row_count_reg[11:0];
                        res.pixel_column   = column_count_reg[11:0];
                        column_count_next  = column_inc;
                        if (column_inc == width_reg)
                        begin
                            column_count_next = '0;
                            row_count_next    = row_inc;
                            padding_left_next = width_reg[1:0];
                            if (row_inc == height_reg)
                            begin
                                phase_next     = bsd_pkg::PH_DONE;
                                res.last_pixel = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= bsd_pkg::PH_HEADER;
            byte_position_reg   <= '0;
            signature_reg       <= '0;
            reserved_reg        <= '0;
            pixel_offset_reg    <= '0;
            header_width_reg    <= '0;
            header_height_reg   <= '0;
            bits_reg            <= '0;
            compression_reg     <= '0;
            width_reg           <= '0;
            height_reg          <= '0;
            row_count_reg       <= '0;
            column_count_reg    <= '0;
            triplet_phase_reg   <= '0;
            held_blue_green_reg <= '0;
            padding_left_reg    <= '0;
            result_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg           <= phase_next;
                byte_position_reg   <= byte_position_next;
                signature_reg       <= signature_next;
                reserved_reg        <= reserved_next;
                pixel_offset_reg    <= pixel_offset_next;
                header_width_reg    <= header_width_next;
                header_height_reg   <= header_height_next;
                bits_reg            <= bits_next;
                compression_reg     <= compression_next;
                width_reg           <= width_next;
                height_reg          <= height_next;
                row_count_reg       <= row_count_next;
                column_count_reg    <= column_count_next;
                triplet_phase_reg   <= triplet_phase_next;
                held_blue_green_reg <= held_blue_green_next;
                padding_left_reg    <= padding_left_next;
                result_valid_reg    <= emit;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= res;
    end

    `BSD_ASSERT_NEXT(a_end_rearms, accept && byte_item.end_marker, phase_reg == bsd_pkg::PH_HEADER && byte_position_reg == 32'd0, "end marker did not rearm parser")
    `BSD_ASSERT_NOW(a_row_in_range, phase_reg == bsd_pkg::PH_PIXELS, row_count_reg < height_reg && column_count_reg < width_reg, "pixel counters out of range")
    `BSD_ASSERT_NOW(a_last_is_pixel, result_valid && result_item.last_pixel, result_item.kind == bsd_pkg::KIND_PIXEL, "last pixel flag on non-pixel item")
    `BSD_ASSERT_NEXT(a_last_done, accept && emit && res.last_pixel, phase_reg == bsd_pkg::PH_DONE, "final pixel did not finish image")

endmodule

`default_nettype wire

FILE: tb/bmp24_stream_decoder_top_tb.sv
// Self-checking testbench for the 24-bit BMP stream decoder: driver, monitor, predictor.
`timescale 1ns / 1ps

module bmp24_stream_decoder_top_tb;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEM_TARGET = 800;

    typedef struct {
        logic [15:0] sig;
        logic [31:0] rsv;
        logic [31:0] ofs;
        logic [31:0] w;
        logic [31:0] h;
        logic [15:0] bpp;
        logic [31:0] comp;
        int          hdr_len;
        int          body_len;
    } bmp_file_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  byte_valid = 1'b0;
    logic                  byte_stall;
    bsd_pkg::byte_item_t   byte_item = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    bsd_pkg::result_item_t result_item;

    bsd_pkg::byte_item_t   pending_bytes[$];
    bsd_pkg::result_item_t predicted_results[$];
    bsd_pkg::result_item_t want;
    int           cycle = 0;
    int           results_checked = 0;
    int           mismatches = 0;
    int           hold_left = 0;
    logic         hold_done = 1'b0;
    logic         quiet;

    // decoder state as predicted
    bsd_pkg::phase_t dec_phase;
    logic [31:0]  dec_pos;
    logic [15:0]  dec_sig;
    logic [31:0]  dec_reserved;
    logic [31:0]  dec_offset;
    logic [31:0]  dec_width;
    logic [31:0]  dec_height;
    logic [15:0]  dec_bits;
    logic [31:0]  dec_compression;
    logic [31:0]  dec_row;
    logic [31:0]  dec_col;
    logic [1:0]   dec_triplet;
    logic [15:0]  dec_blue_green;
    logic [1:0]   dec_pad;

    bmp24_stream_decoder_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    always #2 clk = ~clk;

    assign quiet = (cycle >= 700) && (cycle < 1100);

    function automatic logic [31:0] magnitude(input logic [31:0] v);
        return v[31] ? -v : v;
    endfunction

    function automatic int pixel_bytes(input logic [31:0] w, input logic [31:0] h,
                                       input logic [31:0] ofs);
        logic [31:0] ha;
        ha = magnitude(h);
        if (w == 0 || ha == 0)
            return 0;
        return int'(ofs) - 54 + int'(ha) * (3 * int'(w) + int'(w & 3)) - int'(w & 3);
    endfunction

    function automatic bmp_file_t clean_file(input logic [31:0] w, input logic [31:0] h,
                                             input logic [31:0] ofs);
        bmp_file_t f;
        f.sig      = bsd_pkg::BMP_SIGNATURE;
        f.rsv      = '0;
        f.ofs      = ofs;
        f.w        = w;
        f.h        = h;
        f.bpp      = bsd_pkg::BMP_BITS;
        f.comp     = '0;
        f.hdr_len  = 54;
        f.body_len = pixel_bytes(w, h, ofs);
        return f;
    endfunction

    task automatic push_end();
        pending_bytes.push_back(bsd_pkg::byte_item_t'{data_byte: 8'($urandom),
                                                      end_marker: 1'b1});
    endtask

    task automatic push_file(input bmp_file_t f);
        logic [7:0] b;
        for (int i = 0; i < f.hdr_len; i++)
        begin
            b = 8'($urandom);
            if (i < 2) b = f.sig[8*i +: 8];
            else if (i >= 6 && i < 10) b = f.rsv[8*(i-6) +: 8];
            else if (i >= 10 && i < 14) b = f.ofs[8*(i-10) +: 8];
            else if (i >= 18 && i < 22) b = f.w[8*(i-18) +: 8];
            else if (i >= 22 && i < 26) b = f.h[8*(i-22) +: 8];
            else if (i >= 28 && i < 30) b = f.bpp[8*(i-28) +: 8];
            else if (i >= 30 && i < 34) b = f.comp[8*(i-30) +: 8];
            pending_bytes.push_back(bsd_pkg::byte_item_t'{data_byte: b, end_marker: 1'b0});
        end
        for (int i = 0; i < f.body_len; i++)
            pending_bytes.push_back(bsd_pkg::byte_item_t'{data_byte: 8'($urandom),
                                                          end_marker: 1'b0});
        push_end();
    endtask

    task automatic clear_decoder();
        dec_phase       = bsd_pkg::PH_HEADER;
        dec_pos         = '0;
        dec_sig         = '0;
        dec_reserved    = '0;
        dec_offset      = '0;
        dec_width       = '0;
        dec_height      = '0;
        dec_bits        = '0;
        dec_compression = '0;
        dec_row         = '0;
        dec_col         = '0;
        dec_triplet     = '0;
        dec_blue_green  = '0;
        dec_pad         = '0;
    endtask

    task automatic decode_byte(input bsd_pkg::byte_item_t it);
        bsd_pkg::result_item_t r;
        bsd_pkg::phase_t       old_phase;
        logic [31:0]  p;
        logic [31:0]  ha;
        logic [7:0]   b;
        r = '0;
        b = it.data_byte;
        if (it.end_marker)
        begin
            old_phase = dec_phase;
            clear_decoder();
            if (old_phase != bsd_pkg::PH_REJECTED)
            begin
                if (old_phase == bsd_pkg::PH_DONE)
                    r.kind = bsd_pkg::KIND_END_OK;
                else
                    r.kind = bsd_pkg::KIND_TRUNCATED;
                predicted_results.push_back(r);
            end
            return;
        end
        case (dec_phase)
            bsd_pkg::PH_HEADER:
            begin
                p = dec_pos;
                if (p < 2) dec_sig[8*p +: 8] = b;
                else if (p >= 6 && p < 10) dec_reserved[8*(p-6) +: 8] = b;
                else if (p >= 10 && p < 14) dec_offset[8*(p-10) +: 8] = b;
                else if (p >= 18 && p < 22) dec_width[8*(p-18) +: 8] = b;
                else if (p >= 22 && p < 26) dec_height[8*(p-22) +: 8] = b;
                else if (p >= 28 && p < 30) dec_bits[8*(p-28) +: 8] = b;
                else if (p >= 30 && p < 34) dec_compression[8*(p-30) +: 8] = b;
                dec_pos = p + 1;
                if (p == bsd_pkg::FILE_HEADER_END)
                begin
                    if (dec_sig != bsd_pkg::BMP_SIGNATURE || dec_reserved != 0 ||
                        dec_offset < bsd_pkg::HEADER_BYTES)
                    begin
                        dec_phase = bsd_pkg::PH_REJECTED;
                        r.kind = bsd_pkg::KIND_INVALID;
                        predicted_results.push_back(r);
                    end
                end
                else if (p == bsd_pkg::INFO_HEADER_END)
                begin
                    ha = magnitude(dec_height);
                    if (dec_bits != bsd_pkg::BMP_BITS || dec_compression != 0 ||
                        dec_width > bsd_pkg::MAX_WIDTH || ha > bsd_pkg::MAX_HEIGHT)
                    begin
                        dec_phase = bsd_pkg::PH_REJECTED;
                        r.kind = bsd_pkg::KIND_INVALID;
                    end
                    else
                    begin
                        if (dec_width == 0 || ha == 0)
                            dec_phase = bsd_pkg::PH_DONE;
                        else if (dec_offset == bsd_pkg::HEADER_BYTES)
                            dec_phase = bsd_pkg::PH_PIXELS;
                        else
                            dec_phase = bsd_pkg::PH_SKIP;
                        r.kind = bsd_pkg::KIND_HEADER_OK;
                        r.image_width = dec_width[12:0];
                        r.image_height = ha[12:0];
                    end
                    predicted_results.push_back(r);
                end
            end
            bsd_pkg::PH_SKIP:
            begin
                dec_pos = dec_pos + 1;
                if (dec_pos == dec_offset)
                    dec_phase = bsd_pkg::PH_PIXELS;
            end
            bsd_pkg::PH_PIXELS:
            begin
                if (dec_pad != 2'd0)
                    dec_pad = dec_pad - 2'd1;
                else if (dec_triplet == 2'd0)
                begin
                    dec_blue_green = {b, 8'h00};
                    dec_triplet = 2'd1;
                end
                else if (dec_triplet == 2'd1)
                begin
                    dec_blue_green[7:0] = b;
                    dec_triplet = 2'd2;
                end
                else
                begin
                    dec_triplet = 2'd0;
                    r.kind = bsd_pkg::KIND_PIXEL;
                    r.pixel_value = {bsd_pkg::ALPHA_OPAQUE, dec_blue_green, b};
                    r.pixel_row = dec_row[11:0];
                    r.pixel_column = dec_col[11:0];
                    dec_col = dec_col + 1;
                    if (dec_col == dec_width)
                    begin
                        dec_col = 0;
                        dec_row = dec_row + 1;
                        dec_pad = dec_width[1:0];
                        if (dec_row == magnitude(dec_height))
                        begin
                            dec_phase = bsd_pkg::PH_DONE;
                            r.last_pixel = 1'b1;
                        end
                    end
                    predicted_results.push_back(r);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
        if (exp_val !== got_val)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_item  <= '0;
            clear_decoder();
        end
        else
        begin
            if (byte_valid && !byte_stall)
                decode_byte(byte_item);
            if (!byte_valid || !byte_stall)
            begin
                if (pending_bytes.size() != 0 && (quiet || $urandom_range(0, 99) >= 31))
                begin
                    byte_valid <= 1'b1;
                    byte_item  <= pending_bytes.pop_front();
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, once
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && results_checked >= 8)
        begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("result with nothing predicted, kind %0d", result_item.kind);
                    mismatches++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("kind", want.kind, result_item.kind);
                    check_field("pixel_value", want.pixel_value, result_item.pixel_value);
                    check_field("pixel_row", want.pixel_row, result_item.pixel_row);
                    check_field("pixel_column", want.pixel_column, result_item.pixel_column);
                    check_field("image_width", want.image_width, result_item.image_width);
                    check_field("image_height", want.image_height, result_item.image_height);
                    check_field("last_pixel", want.last_pixel, result_item.last_pixel);
                    results_checked <= results_checked + 1;
                end
            end
            result_stall <= (hold_left != 0) || (!quiet && $urandom_range(0, 99) < 31);
        end
    end

    initial
    begin
        bmp_file_t f;
        int        sel;
        int        hsz;
        int        waited;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] ofs;

        // directed files
        push_end();
        push_file(clean_file(2, 2, 54));
        f = clean_file(3, -2, 57);
        f.body_len += 5;
        push_file(f);
        f = clean_file(0, 5, 60);
        f.body_len = 4;
        push_file(f);
        for (int k = 0; k < 8; k++)
        begin
            f = clean_file(1, 1, 54);
            case (k)
                0: f.sig = 16'h4D43;
                1: f.rsv = 32'h0001_0000;
                2: f.ofs = 53;
                3: f.bpp = 16'd32;
                4: f.comp = 32'd1;
                5: f.w = 32'hFFFF_FFFF;
                6: f.h = -4097;
                default: f.h = 32'h8000_0000;
            endcase
            f.body_len = 0;
            if (k < 3)
                f.hdr_len = 14;
            push_file(f);
        end
        f = clean_file(2, 2, 54);
        f.hdr_len = 13;
        push_file(f);
        f = clean_file(4096, -4096, 54);
        f.body_len = 6;
        push_file(f);

        // random files: mostly well formed, some cut short, corrupted or noise
        while (pending_bytes.size() < ITEM_TARGET)
        begin
            sel = $urandom_range(0, 99);
            w = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
            hsz = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
            h = $urandom_range(0, 1) ? -hsz : hsz;
            ofs = 54 + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0);
            f = clean_file(w, h, ofs);
            if (sel < 65)
                f.body_len += $urandom_range(0, 3);
            else if (sel < 78)
            begin
                if ($urandom_range(0, 1))
                    f.hdr_len = $urandom_range(0, 53);
                else
                    f.body_len = $urandom_range(0, f.body_len);
            end
            else if (sel < 90)
            begin
                case ($urandom_range(0, 6))
                    0: f.sig ^= 16'(1) << $urandom_range(0, 15);
                    1: f.rsv ^= 32'(1) << $urandom_range(0, 31);
                    2: f.ofs ^= 32'(1) << $urandom_range(0, 7);
                    3: f.bpp ^= 16'(1) << $urandom_range(0, 15);
                    4: f.comp ^= 32'(1) << $urandom_range(0, 31);
                    5: f.w ^= 32'(1) << $urandom_range(0, 31);
                    default: f.h ^= 32'(1) << $urandom_range(0, 31);
                endcase
                f.body_len = $urandom_range(0, 30);
            end
            else
            begin
                repeat ($urandom_range(1, 40))
                    pending_bytes.push_back(bsd_pkg::byte_item_t'{
                        data_byte: 8'($urandom),
                        end_marker: ($urandom_range(0, 7) == 0)});
                continue;
            end
            push_file(f);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || byte_valid)
            @(posedge clk);
        waited = 0;
        while (predicted_results.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (predicted_results.size() != 0)
        begin
            $error("%0d predicted results never arrived", predicted_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
